// ===== design/msequence_generator_defines.svh =====
// ----------------------------------------------------------------------------
// msequence_generator_defines
// Assertion macros for the sequence generator RTL.
// ----------------------------------------------------------------------------
`ifndef MSEQUENCE_GENERATOR_DEFINES_SVH
`define MSEQUENCE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define MSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/msg_pkg.sv =====
// ----------------------------------------------------------------------------
// msg_pkg
// Types and constants of the maximal-length sequence generator.
// ----------------------------------------------------------------------------
package msg_pkg;

    // Field and register widths
    localparam int DEGREE_W       = 5;
    localparam int TAPS_W         = 16;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    // Default largest degree and register reset value
    localparam int MAX_DEGREE_DEF = 16;
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 5'd7;

    // Register index, taken from paddr bit 2
    localparam logic REG_DEGREE = 1'b0;

    // Configuration event from the register block
    typedef struct packed {
        logic                wr;
        logic [DEGREE_W-1:0] degree;
    } t_cfg;

    // Search unit control and status
    typedef struct packed {
        logic start;
    } t_search_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_search_sts;

endpackage

// ===== design/msg_ifs.sv =====
// ----------------------------------------------------------------------------
// msg_ifs
// Valid/ready channels for restart requests and sequence bits.
// ----------------------------------------------------------------------------
interface msg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface msg_out_if;
    logic                       valid;
    logic                       ready;
    logic                       seq_bit;
    logic                       period_end;
    logic [msg_pkg::TAPS_W-1:0] feedback_taps;

    modport source (output valid, output seq_bit, output period_end,
                    output feedback_taps, input ready);
    modport sink (input valid, input seq_bit, input period_end,
                  input feedback_taps, output ready);
endinterface

// ===== design/msg_apb.sv =====
// ----------------------------------------------------------------------------
// msg_apb
// APB register block: holds the degree register and flags each write to it.
// ----------------------------------------------------------------------------
module msg_apb #(
    parameter int MAX_DEGREE = msg_pkg::MAX_DEGREE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [msg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [msg_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output msg_pkg::t_cfg                  o_cfg
);

    localparam int DW = msg_pkg::DEGREE_W;

    logic [DW-1:0] r_degree;
    logic [DW-1:0] n_degree;
    logic          wr_hit;
    logic          sel_degree;

    assign pready     = 1'b1;
    assign sel_degree = (paddr[2] == msg_pkg::REG_DEGREE);
    assign wr_hit     = psel & penable & pwrite & sel_degree;

    // Take the low bits of the write data
    always_comb begin
        n_degree = r_degree;
        if (wr_hit) begin
            n_degree = pwdata[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= msg_pkg::DEGREE_RESET;
        end else begin
            r_degree <= n_degree;
        end
    end

    // Read back the stored degree
    assign prdata = sel_degree ? {{(msg_pkg::APB_DATA_W-DW){1'b0}}, r_degree} : '0;

    // Clamp the degree into 1..MAX_DEGREE for the datapath
    always_comb begin
        o_cfg.wr     = wr_hit;
        o_cfg.degree = r_degree;
        if (r_degree == '0) begin
            o_cfg.degree = DW'(1);
        end else if (r_degree > DW'(MAX_DEGREE)) begin
            o_cfg.degree = DW'(MAX_DEGREE);
        end
    end

endmodule

// ===== design/msg_search.sv =====
// ----------------------------------------------------------------------------
// msg_search
// Primitive polynomial search: one shared reduce/compare/shift step per cycle
// walks x^k mod (2^n | i) over odd low parts i until the order is 2^n-1,
// or gives zero taps when no candidate is left.
module msg_search #(
    parameter int MAX_DEGREE = msg_pkg::MAX_DEGREE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  msg_pkg::t_search_ctl         i_ctl,
    input  logic [msg_pkg::DEGREE_W-1:0] i_degree,
    output msg_pkg::t_search_sts         o_sts,
    output logic [MAX_DEGREE-1:0]        o_taps
);

    localparam int KW = MAX_DEGREE;
    localparam int AW = MAX_DEGREE + 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [KW-1:0] r_low,  n_low;
    logic [AW-1:0] r_acc,  n_acc;
    logic [KW-1:0] r_k,    n_k;
    logic [KW-1:0] r_taps, n_taps;

    logic [AW-1:0] top_w;
    logic [AW-1:0] top_m1;
    logic [AW-1:0] poly;
    logic [AW-1:0] acc_red;
    logic          hit_one;
    logic          k_last;
    logic          low_last;

    // Shared step: reduce by the candidate, test for one, test the order
    assign top_w    = AW'(1) << i_degree;
    assign top_m1   = top_w - AW'(1);
    assign poly     = top_w | {1'b0, r_low};
    assign acc_red  = ((r_acc & top_w) != '0) ? (r_acc ^ poly) : r_acc;
    assign hit_one  = (acc_red == AW'(1));
    assign k_last   = (r_k == top_m1[KW-1:0]);
    assign low_last = (r_low == top_m1[KW-1:0]);

    // Sequence candidates and powers
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_low  = r_low;
        n_acc  = r_acc;
        n_k    = r_k;
        n_taps = r_taps;
        if (!r_busy) begin
            if (i_ctl.start) begin
                n_busy = 1'b1;
                n_low  = KW'(1);
                n_acc  = top_w;
                n_k    = KW'(i_degree);
                n_taps = '0;
            end
        end else if (hit_one && k_last) begin
            // order is full: keep this polynomial
            n_busy = 1'b0;
            n_done = 1'b1;
            n_taps = poly[AW-1:1];
        end else if (hit_one || k_last) begin
            // order too short or loop ran out: next candidate, or zero taps if none left
            if (low_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_taps = '0;
            end else begin
                n_low = r_low + KW'(2);
                n_acc = top_w;
                n_k   = KW'(i_degree);
            end
        end else begin
            n_acc = acc_red << 1;
            n_k   = r_k + KW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_taps <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_taps <= n_taps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_low <= n_low;
        r_acc <= n_acc;
        r_k   <= n_k;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_taps     = r_taps;

endmodule

// ===== design/msequence_generator.sv =====
// ----------------------------------------------------------------------------
// msequence_generator
// Maximal-length sequence generator: searches a primitive polynomial for
// the programmed degree, then steps a right-shifting Galois LFSR per item.
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   i_item    in   valid/ready        restart
//   o_result  out  valid/ready        seq_bit, period_end, feedback_taps
//   apb       in   psel/penable       degree register at byte address 0
//
// An item whose polynomial is known gets one LFSR step into the output
// register, valid in the cycle after acceptance. The first item after reset
// or a degree write first runs the search, one reduce/shift step per cycle;
// the step state then makes the LFSR step. Reset is synchronous; no
// clearing pass. A stalled result holds and blocks the next item only
// until it is taken.
// ----------------------------------------------------------------------------
module msequence_generator #(
    parameter int MAX_DEGREE = msg_pkg::MAX_DEGREE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [msg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [msg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [msg_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    msg_in_if.sink                         i_item,
    msg_out_if.source                      o_result
);

    `include "msequence_generator_defines.svh"

    localparam int KW = MAX_DEGREE;
    localparam int AW = MAX_DEGREE + 1;
    localparam int TW = msg_pkg::TAPS_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_STEP   = 2'd2;

    msg_pkg::t_cfg        cfg;
    msg_pkg::t_search_ctl search_ctl;
    msg_pkg::t_search_sts search_sts;
    logic [KW-1:0]        search_taps;

    logic [1:0]    r_state, n_state;
    logic          r_poly_ready, n_poly_ready;
    logic [KW-1:0] r_taps, n_taps;
    logic [KW-1:0] r_lfsr, n_lfsr;
    logic [KW-1:0] r_pos, n_pos;
    logic          r_out_valid, n_out_valid;
    logic          r_seq_bit, n_seq_bit;
    logic          r_period_end, n_period_end;
    logic [TW-1:0] r_taps_out, n_taps_out;

    logic             accept;
    logic             do_step;
    logic             fresh;
    logic [KW-1:0]    base_lfsr;
    logic [KW-1:0]    base_pos;
    logic [KW-1:0]    step_lfsr;
    logic [AW-1:0]    top_m2;
    logic [KW-1:0]    last_pos;
    logic [KW+TW-1:0] taps_wide;

    msg_apb #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msg_search #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (search_ctl),
        .i_degree (cfg.degree),
        .o_sts    (search_sts),
        .o_taps   (search_taps)
    );

    // Take an item only when idle and the output slot frees up
    assign i_item.ready = (r_state == ST_IDLE) && (!r_out_valid || o_result.ready);
    assign accept       = i_item.valid && i_item.ready;

    assign search_ctl.start = accept && !r_poly_ready;

    // One Galois step from either the held state or a fresh start
    assign do_step   = (accept && r_poly_ready) || (r_state == ST_STEP);
    assign fresh     = (r_state == ST_IDLE) && i_item.restart;
    assign base_lfsr = fresh ? KW'(1) : r_lfsr;
    assign base_pos  = fresh ? '0 : r_pos;
    assign step_lfsr = (base_lfsr >> 1) ^ (base_lfsr[0] ? r_taps : '0);
    assign top_m2    = (AW'(1) << cfg.degree) - AW'(2);
    assign last_pos  = top_m2[KW-1:0];
    assign taps_wide = {{TW{1'b0}}, r_taps};

    always_comb begin
        n_state      = r_state;
        n_poly_ready = r_poly_ready;
        n_taps       = r_taps;
        n_lfsr       = r_lfsr;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid;
        n_seq_bit    = r_seq_bit;
        n_period_end = r_period_end;
        n_taps_out   = r_taps_out;

        // drop the result once taken
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        // a degree write forces a new search
        if (cfg.wr) begin
            n_poly_ready = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (search_ctl.start) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_sts.done) begin
                    n_taps       = search_taps;
                    n_lfsr       = KW'(1);
                    n_pos        = '0;
                    n_poly_ready = 1'b1;
                    n_state      = ST_STEP;
                end
            end
            ST_STEP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // advance the LFSR and load the result
        if (do_step) begin
            n_lfsr       = step_lfsr;
            n_pos        = (base_pos >= last_pos) ? '0 : base_pos + KW'(1);
            n_out_valid  = 1'b1;
            n_seq_bit    = step_lfsr[0];
            n_period_end = (base_pos == last_pos);
            n_taps_out   = taps_wide[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_poly_ready <= 1'b0;
            r_taps       <= '0;
            r_lfsr       <= KW'(1);
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_poly_ready <= n_poly_ready;
            r_taps       <= n_taps;
            r_lfsr       <= n_lfsr;
            r_pos        <= n_pos;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq_bit    <= n_seq_bit;
        r_period_end <= n_period_end;
        r_taps_out   <= n_taps_out;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.seq_bit       = r_seq_bit;
    assign o_result.period_end    = r_period_end;
    assign o_result.feedback_taps = r_taps_out;

    // Checks on sequencing and search results
    `MSG_ASSERT_NOW(a_busy_not_ready, r_state != ST_IDLE, !i_item.ready, "ready while busy")
    `MSG_ASSERT_NOW(a_done_in_search, search_sts.done, r_state == ST_SEARCH, "stray search done")
    `MSG_ASSERT_NOW(a_busy_search, search_sts.busy, r_state == ST_SEARCH, "stray busy")
    `MSG_ASSERT_NEXT(a_step_loads, r_state == ST_STEP, r_out_valid, "step gave no result")
    `MSG_ASSERT_NOW(a_taps_found, r_poly_ready, r_taps != '0, "no polynomial found")

endmodule

// ===== tb/sv/msequence_generator_tb.sv =====
// ----------------------------------------------------------------------------
// msequence_generator_tb
// Self-checking bench for the maximal-length sequence generator. An internal
// model searches the same primitive polynomial and steps the same Galois LFSR
// for every accepted item. The run starts with a table of directed rows
// (reset default, extreme and clamped degrees, restarts, an unmapped register
// write), then goes through random phases that each open with a degree or
// unmapped register write. Most send long, restart-sparse runs that cross
// period ends at small degrees; every fourth phase restarts often. Both
// channels idle at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module msequence_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS_W     = msg_pkg::TAPS_W;
    localparam int APB_ADDR_W = msg_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = msg_pkg::APB_DATA_W;
    localparam int DEGREE_W   = msg_pkg::DEGREE_W;

    typedef struct packed {
        logic              seq_bit;
        logic              period_end;
        logic [TAPS_W-1:0] feedback_taps;
    } t_seq_result;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SET_DEGREE,
        ROW_SET_UNMAPPED
    } t_row_kind;

    // Item rows carry the restart bit in value[0]; register rows carry pwdata
    typedef struct packed {
        t_row_kind       kind;
        logic [31:0]     value;
        logic            typed;
        t_seq_result     want;
    } t_stim_row;

    localparam logic [APB_ADDR_W-1:0] DEGREE_ADDR   = APB_ADDR_W'(0);
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = APB_ADDR_W'(4);
    localparam int          ITEM_TARGET   = 950;
    localparam int          CALM_ITEMS    = 120;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          DRAIN_CYCLES  = 20;
    // A degree-16 search accepts no item while it runs
    localparam int          STALL_LIMIT   = 6_000_000;
    localparam t_seq_result NO_RESULT     = '0;
    localparam int          DIRECTED_ROWS = 26;

    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // Reset degree 7: the first item runs the pending search
        '{ROW_ITEM,         32'd0,         1'b1, '{1'b1, 1'b0, 16'h0041}},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd1,         1'b1, '{1'b1, 1'b0, 16'h0041}},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        // Smallest degree: every bit is one and ends a period
        '{ROW_SET_DEGREE,   32'd1,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b1, '{1'b1, 1'b1, 16'h0001}},
        '{ROW_ITEM,         32'd1,         1'b1, '{1'b1, 1'b1, 16'h0001}},
        '{ROW_ITEM,         32'd0,         1'b1, '{1'b1, 1'b1, 16'h0001}},
        // Degree zero is clamped to one; upper data bits are don't-care
        '{ROW_SET_DEGREE,   32'hFFFF_FFE0, 1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b1, '{1'b1, 1'b1, 16'h0001}},
        '{ROW_ITEM,         32'd1,         1'b1, '{1'b1, 1'b1, 16'h0001}},
        // Degree 2 through a full period
        '{ROW_SET_DEGREE,   32'h5A5A_5A42, 1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b1, '{1'b1, 1'b0, 16'h0003}},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        // Unmapped register: ignored, the sequence continues
        '{ROW_SET_UNMAPPED, 32'h0000_0005, 1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd1,         1'b0, NO_RESULT},
        // Largest degree, then a degree above it that clamps to the largest
        '{ROW_SET_DEGREE,   32'd16,        1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_SET_DEGREE,   32'd31,        1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT},
        '{ROW_ITEM,         32'd0,         1'b0, NO_RESULT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    msg_in_if  item_if ();
    msg_out_if result_if ();

    msequence_generator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_item   (item_if),
        .o_result (result_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state, at its reset values
    logic [DEGREE_W-1:0] degree_q   = msg_pkg::DEGREE_RESET;
    logic [TAPS_W-1:0]   taps_q     = '0;
    logic [TAPS_W-1:0]   lfsr_q     = TAPS_W'(1);
    int                  pos_q      = 0;
    bit                  poly_known = 1'b0;

    t_seq_result pending_bits [$];
    bit          typed_pending = 1'b0;
    t_seq_result typed_want    = NO_RESULT;
    bit          calm          = 1'b0;
    bit          hold_req      = 1'b0;
    int          errors        = 0;
    int          items_in      = 0;
    int          results_out   = 0;
    int          restarts_in   = 0;
    int          period_ends   = 0;
    int          reg_writes    = 0;
    int          quiet_cycles  = 0;

    // First odd low part whose polynomial makes x of full order 2^n-1
    function automatic logic [TAPS_W-1:0] find_taps(input int n);
        longint unsigned top;
        longint unsigned poly;
        longint unsigned acc;
        longint unsigned low;
        longint unsigned k;
        bit              full;
        top = 64'd1 << n;
        for (low = 1; low < top; low += 2) begin
            poly = top | low;
            acc  = top;
            full = 1'b0;
            for (k = n; k < top; k++) begin
                if ((acc & top) != 0) acc ^= poly;
                if (acc == 1) begin
                    full = (k == top - 1);
                    break;
                end
                acc <<= 1;
            end
            if (full) return TAPS_W'(poly >> 1);
        end
        return '0;
    endfunction

    // Advance the model by one item and return the bit it yields
    function automatic t_seq_result next_sequence_bit(input logic restart_bit);
        int          n;
        int          last;
        t_seq_result res;
        n = int'(degree_q);
        if (n < 1) n = 1;
        if (n > msg_pkg::MAX_DEGREE_DEF) n = msg_pkg::MAX_DEGREE_DEF;
        last = (1 << n) - 2;
        if (restart_bit || !poly_known) begin
            taps_q     = find_taps(n);
            lfsr_q     = TAPS_W'(1);
            pos_q      = 0;
            poly_known = 1'b1;
        end
        lfsr_q = (lfsr_q >> 1) ^ (lfsr_q[0] ? taps_q : '0);
        res.seq_bit       = lfsr_q[0];
        res.period_end    = (pos_q == last);
        res.feedback_taps = taps_q;
        if (pos_q >= last) pos_q = 0;
        else pos_q++;
        return res;
    endfunction

    // Compare results in order, then predict for the item taken at this edge
    always @(posedge i_clk) begin : check_p
        t_seq_result want;
        t_seq_result predicted;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            results_out++;
            if (result_if.period_end === 1'b1) period_ends++;
            if (pending_bits.size() == 0) begin
                $error("result arrived with no item outstanding");
                errors++;
            end else begin
                want = pending_bits.pop_front();
                if (result_if.seq_bit !== want.seq_bit) begin
                    $error("seq_bit: expected %0d, actual %0d",
                           want.seq_bit, result_if.seq_bit);
                    errors++;
                end
                if (result_if.period_end !== want.period_end) begin
                    $error("period_end: expected %0d, actual %0d",
                           want.period_end, result_if.period_end);
                    errors++;
                end
                if (result_if.feedback_taps !== want.feedback_taps) begin
                    $error("feedback_taps: expected %04h, actual %04h",
                           want.feedback_taps, result_if.feedback_taps);
                    errors++;
                end
            end
        end
        if (i_rst_n && item_if.valid && item_if.ready) begin
            items_in++;
            if (item_if.restart) restarts_in++;
            predicted = next_sequence_bit(item_if.restart);
            pending_bits.push_back(typed_pending ? typed_want : predicted);
        end
    end

    // Stop a run in which nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (item_if.valid && item_if.ready)
                || (result_if.valid && result_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive ready: random stalls, long hold-off on request, none when calm
    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // Offer one item and hold it until taken; return on a falling edge
    task automatic send_item(input logic restart_bit);
        item_if.valid   <= 1'b1;
        item_if.restart <= restart_bit;
        do @(posedge i_clk); while (!item_if.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        item_if.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        do @(negedge i_clk); while (pending_bits.size() != 0);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        reg_writes++;
        if (addr == DEGREE_ADDR) begin
            degree_q   = data[DEGREE_W-1:0];
            poly_known = 1'b0;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Write the degree and read it back
    task automatic write_degree(input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] want;
        apb_write(DEGREE_ADDR, data);
        want    = APB_DATA_W'(data[DEGREE_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DEGREE_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("degree readback: expected %0h, actual %0h", want, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        t_stim_row           row;
        int                  items_left;
        int                  phase;
        int                  phase_len;
        int                  odds;
        int                  pick;
        logic [DEGREE_W-1:0] new_deg;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        item_if.valid   = 1'b0;
        item_if.restart = 1'b0;
        result_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            row = directed_rows[r];
            case (row.kind)
                ROW_ITEM: begin
                    if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 15));
                    typed_pending = row.typed;
                    typed_want    = row.want;
                    send_item(row.value[0]);
                end
                ROW_SET_DEGREE: begin
                    wait_idle();
                    write_degree(row.value);
                end
                ROW_SET_UNMAPPED: begin
                    wait_idle();
                    apb_write(UNMAPPED_ADDR, row.value);
                end
                default: ;
            endcase
        end
        typed_pending = 1'b0;

        // Random phases: long runs across period ends, restarts sparse but in noisy phases
        items_left = ITEM_TARGET - items_in;
        phase      = 0;
        while (items_left > 0) begin
            wait_idle();
            if (phase % 6 == 5) begin
                // Unmapped write only: the running sequence must carry on
                apb_write(UNMAPPED_ADDR, $urandom());
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 2) new_deg = DEGREE_W'($urandom_range(0, 1));
                else if (pick < 14) new_deg = DEGREE_W'($urandom_range(2, 6));
                else new_deg = DEGREE_W'($urandom_range(7, 10));
                write_degree(($urandom() & ~32'h1F) | APB_DATA_W'(new_deg));
            end
            phase_len = $urandom_range(90, 140);
            if (phase_len > items_left) phase_len = items_left;
            // Every fourth phase is noisy with frequent restarts
            odds = (phase % 4 == 3) ? 4 : 40;
            if (phase == 1) hold_req = 1'b1;
            repeat (phase_len) begin
                if (items_left <= CALM_ITEMS) calm = 1'b1;
                if (!calm && !hold_req && $urandom_range(0, 4) == 0) begin
                    idle_gap($urandom_range(1, 15));
                end
                send_item($urandom_range(0, odds - 1) == 0);
                items_left--;
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run summary: %0d items (%0d restarts), %0d register writes,",
                 items_in, restarts_in, reg_writes);
        $display("  %0d sequence bits checked, %0d period boundaries seen",
                 results_out, period_ends);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== msequence_generator.f =====
+incdir+design
design/msg_pkg.sv
design/msg_ifs.sv
design/msg_apb.sv
design/msg_search.sv
design/msequence_generator.sv
tb/sv/msequence_generator_tb.sv
